// File: sv/dpw_pkg.sv
package dpw_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 8'd1;

  localparam logic [19:0] ACCEL_GAIN_RST = 20'd41698;
  localparam logic [15:0] DAMPING_RST    = 16'd64225;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam int unsigned MUL_A_W = 17;
  localparam int unsigned MUL_B_W = 21;
  localparam int unsigned MUL_P_W = 38;

  typedef struct packed {
    logic              mode;
    logic [5:0]        particle_index;
    logic [6:0]        load_x;
    logic [5:0]        load_y;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
  } in_t;

  typedef struct packed {
    logic [5:0] which_particle;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [14:0]        pos_x;
    logic [13:0]        pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } entry_t;

endpackage

// File: sv/dpw_mul.sv
module dpw_mul (
  input  logic                                clk_i,
  input  logic signed [dpw_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [dpw_pkg::MUL_B_W-1:0] b_i,
  output logic signed [dpw_pkg::MUL_P_W-1:0] p_o
);
  import dpw_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i * b_i);
  end

  assign p_o = p_q;

endmodule

// File: sv/dpw_store.sv
module dpw_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  dpw_pkg::entry_t       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output dpw_pkg::entry_t       rd_data_o
);
  import dpw_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  entry_t           rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never written entries read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: sv/damped_particle_wall_bounce_step_unit.sv
// load beat: particle stored at the accepting edge, no result
// tick beat: setup states S_GX, S_GY, S_GD, then states S_RD, S_VX, S_VY, S_MX, S_MY
// for each particle, S_MY holding while the output stalls; one tick at a time
// the per-particle step is set by the single shared multiplier used twice per particle
// and the particle store read and written once per particle
// reset: registers to defaults, all particles read as zero until loaded, no clearing pass
module damped_particle_wall_bounce_step_unit #(
  parameter int unsigned PARTICLE_COUNT = 64,
  parameter int unsigned FIELD_WIDTH    = 128,
  parameter int unsigned FIELD_HEIGHT   = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  dpw_pkg::in_t                       in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output dpw_pkg::out_t                      out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dpw_pkg::*;

  localparam int unsigned IDX_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLE_COUNT - 1);
  localparam logic signed [17:0] X_LIM   = 18'(FIELD_WIDTH * 256);
  localparam logic signed [17:0] Y_LIM   = 18'(FIELD_HEIGHT * 256);
  localparam logic [14:0]        X_CLAMP = 15'((FIELD_WIDTH - 1) * 256);
  localparam logic [14:0]        Y_CLAMP = 15'((FIELD_HEIGHT - 1) * 256);

  typedef enum logic [3:0] {
    S_IDLE, S_GX, S_GY, S_GD, S_RD, S_VX, S_VY, S_MX, S_MY
  } state_e;

  state_e state_q;
  logic [IDX_W-1:0]   idx_q;
  logic signed [15:0] tilt_x_q, tilt_y_q;
  logic signed [15:0] dvx_q, dvy_q, vxd_q, vyd_q, vxn_q;
  logic [14:0]        pxn_q;
  logic               out_valid_q;
  out_t               out_q;
  logic [19:0]        gain_q;
  logic [15:0]        damp_q;

  logic in_acc, out_free, load_ok, wr_en, step_done;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data, rd_data;
  logic [6:0] lx_c;
  logic [5:0] ly_c;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [MUL_P_W-1:0] rnd22, rnd16;
  logic signed [16:0] vsum;
  logic signed [15:0] vsat;

  logic [14:0]        ax_pos, ax_pos_n, ax_clamp;
  logic signed [15:0] ax_vel, ax_vel_n;
  logic signed [17:0] ax_lim, ax_p;
  logic signed [16:0] ax_v2, ax_neg;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step_done   = (state_q == S_MY) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= ACCEL_GAIN_RST;
      damp_q <= DAMPING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_ACCEL_GAIN) begin
        gain_q <= cfg_data_i[19:0];
      end else if (cfg_index_i == CFG_DAMPING) begin
        damp_q <= cfg_data_i[15:0];
      end
    end
  end

  // load coordinates clamped to the field
  always_comb begin
    lx_c = in_data_i.load_x;
    ly_c = in_data_i.load_y;
    if (int'(in_data_i.load_x) > FIELD_WIDTH - 1) begin
      lx_c = 7'(FIELD_WIDTH - 1);
    end
    if (int'(in_data_i.load_y) > FIELD_HEIGHT - 1) begin
      ly_c = 6'(FIELD_HEIGHT - 1);
    end
  end

  assign load_ok = in_acc && (in_data_i.mode == MODE_LOAD) &&
                   (int'(in_data_i.particle_index) < PARTICLE_COUNT);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GX: begin
        mul_a = MUL_A_W'(tilt_x_q);
        mul_b = MUL_B_W'({1'b0, gain_q});
      end
      S_GY: begin
        mul_a = MUL_A_W'(tilt_y_q);
        mul_b = MUL_B_W'({1'b0, gain_q});
      end
      S_VX, S_VY: begin
        mul_a = MUL_A_W'(vsat);
        mul_b = MUL_B_W'({1'b0, damp_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dpw_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign rnd22 = (mul_p + MUL_P_W'(1 << 21)) >>> 22;
  assign rnd16 = (mul_p + MUL_P_W'(1 << 15)) >>> 16;

  // saturated velocity plus acceleration
  always_comb begin
    if (state_q == S_VY) begin
      vsum = 17'(rd_data.vel_y) + 17'(dvy_q);
    end else begin
      vsum = 17'(rd_data.vel_x) + 17'(dvx_q);
    end
    if (vsum > 17'sd32767) begin
      vsat = 16'sd32767;
    end else if (vsum < -17'sd32768) begin
      vsat = -16'sd32768;
    end else begin
      vsat = vsum[15:0];
    end
  end

  // shared move and wall bounce, x in S_MX and y in S_MY
  always_comb begin
    if (state_q == S_MY) begin
      ax_pos   = {1'b0, rd_data.pos_y};
      ax_vel   = vyd_q;
      ax_lim   = Y_LIM;
      ax_clamp = Y_CLAMP;
    end else begin
      ax_pos   = rd_data.pos_x;
      ax_vel   = vxd_q;
      ax_lim   = X_LIM;
      ax_clamp = X_CLAMP;
    end
    ax_v2    = (17'(ax_vel) + 17'sd2) >>> 2;
    ax_p     = $signed({3'b000, ax_pos}) + 18'(ax_v2);
    ax_neg   = (-17'(ax_vel)) >>> 1;
    ax_pos_n = ax_p[14:0];
    ax_vel_n = ax_vel;
    if (ax_p[17]) begin
      ax_pos_n = '0;
      ax_vel_n = ax_neg[15:0];
    end else if (ax_p >= ax_lim) begin
      ax_pos_n = ax_clamp;
      ax_vel_n = ax_neg[15:0];
    end
  end

  always_comb begin
    if (state_q == S_MY) begin
      wr_en         = step_done;
      wr_addr       = idx_q;
      wr_data.pos_x = pxn_q;
      wr_data.pos_y = ax_pos_n[13:0];
      wr_data.vel_x = vxn_q;
      wr_data.vel_y = ax_vel_n;
    end else begin
      wr_en         = load_ok;
      wr_addr       = in_data_i.particle_index[IDX_W-1:0];
      wr_data.pos_x = {lx_c, 8'd0};
      wr_data.pos_y = {ly_c, 8'd0};
      wr_data.vel_x = '0;
      wr_data.vel_y = '0;
    end
  end

  dpw_store #(
    .DEPTH (PARTICLE_COUNT),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (state_q == S_RD),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      tilt_x_q    <= '0;
      tilt_y_q    <= '0;
      dvx_q       <= '0;
      dvy_q       <= '0;
      vxd_q       <= '0;
      vyd_q       <= '0;
      vxn_q       <= '0;
      pxn_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (!out_stall_i && !step_done) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.mode == MODE_TICK) begin
            tilt_x_q <= in_data_i.tilt_x;
            tilt_y_q <= in_data_i.tilt_y;
            state_q  <= S_GX;
          end
        end
        S_GX: begin
          state_q <= S_GY;
        end
        S_GY: begin
          dvx_q   <= rnd22[15:0];
          state_q <= S_GD;
        end
        S_GD: begin
          dvy_q   <= rnd22[15:0];
          idx_q   <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_VX;
        end
        S_VX: begin
          state_q <= S_VY;
        end
        S_VY: begin
          vxd_q   <= rnd16[15:0];
          state_q <= S_MX;
        end
        S_MX: begin
          vyd_q   <= rnd16[15:0];
          pxn_q   <= ax_pos_n;
          vxn_q   <= ax_vel_n;
          state_q <= S_MY;
        end
        S_MY: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.which_particle <= 6'(idx_q);
            out_q.pixel_x        <= pxn_q[14:8];
            out_q.pixel_y        <= ax_pos_n[13:8];
            out_q.last           <= (idx_q == LAST_IDX);
            if (idx_q == LAST_IDX) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_MY))
    else $error("result appeared outside a particle step");

  a_last_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_done && idx_q == LAST_IDX) |=> (state_q == S_IDLE) && out_valid_o && out_data_o.last)
    else $error("final particle did not close the tick");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (idx_q <= LAST_IDX))
    else $error("particle index beyond table");

endmodule

// File: tb/dpw_checker.sv
`timescale 1ns / 1ps

module dpw_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  dpw_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  dpw_pkg::out_t                  out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    tick_count_o,
  output int unsigned                    load_count_o,
  output int unsigned                    pixel_count_o,
  output int unsigned                    cfg_count_o
);
  import dpw_pkg::*;

  localparam int NUM_PARTICLES = 64;
  localparam int FIELD_W       = 128;
  localparam int FIELD_H       = 64;

  logic [19:0]        gain_q;
  logic [15:0]        damp_q;
  logic [14:0]        pos_x [NUM_PARTICLES];
  logic [13:0]        pos_y [NUM_PARTICLES];
  logic signed [15:0] vel_x [NUM_PARTICLES];
  logic signed [15:0] vel_y [NUM_PARTICLES];

  out_t        pending_pixels [$];
  int unsigned fail_count;
  int unsigned tick_count;
  int unsigned load_count;
  int unsigned pixel_count;
  int unsigned cfg_count;
  int unsigned pending;

  assign fail_count_o  = fail_count;
  assign pending_o     = pending;
  assign tick_count_o  = tick_count;
  assign load_count_o  = load_count;
  assign pixel_count_o = pixel_count;
  assign cfg_count_o   = cfg_count;

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one axis: tilt kick, damping, move, edge bounce
  function automatic void move_axis(inout longint pos, inout longint vel, input longint tilt,
                                    input longint extent);
    longint dv;
    longint v;
    longint p;
    dv = (tilt * longint'(gain_q) + (longint'(1) <<< 21)) >>> 22;
    v  = clip16(vel + dv);
    v  = (v * longint'(damp_q) + (longint'(1) <<< 15)) >>> 16;
    p  = pos + ((v + 2) >>> 2);
    if (p < 0) begin
      p = 0;
      v = (-v) >>> 1;
    end else if (p >= extent * 256) begin
      p = (extent - 1) * 256;
      v = (-v) >>> 1;
    end
    pos = p;
    vel = clip16(v);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: pixel beat %0d, %s expected %0d got %0d", $time, pixel_count, name,
               want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    out_t   want;
    longint tx;
    longint ty;
    longint px;
    longint py;
    longint vx;
    longint vy;
    if (!rst_ni) begin
      gain_q = ACCEL_GAIN_RST;
      damp_q = DAMPING_RST;
      for (int i = 0; i < NUM_PARTICLES; i++) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
        vel_x[i] = '0;
        vel_y[i] = '0;
      end
      pending_pixels.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel beat, expected none got particle %0d (%0d,%0d) last %0d",
                   $time, out_data_i.which_particle, out_data_i.pixel_x, out_data_i.pixel_y,
                   out_data_i.last);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("which_particle", int'(want.which_particle),
                      int'(out_data_i.which_particle));
          check_field("pixel_x", int'(want.pixel_x), int'(out_data_i.pixel_x));
          check_field("pixel_y", int'(want.pixel_y), int'(out_data_i.pixel_y));
          check_field("last", int'(want.last), int'(out_data_i.last));
        end
        pixel_count++;
      end

      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_ACCEL_GAIN) begin
          gain_q = cfg_data_i[19:0];
        end else if (cfg_index_i == CFG_DAMPING) begin
          damp_q = cfg_data_i[15:0];
        end
        cfg_count++;
      end

      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.mode == MODE_TICK) begin
          tx = longint'($signed(in_data_i.tilt_x));
          ty = longint'($signed(in_data_i.tilt_y));
          for (int i = 0; i < NUM_PARTICLES; i++) begin
            px = longint'(pos_x[i]);
            py = longint'(pos_y[i]);
            vx = longint'(vel_x[i]);
            vy = longint'(vel_y[i]);
            move_axis(px, vx, tx, longint'(FIELD_W));
            move_axis(py, vy, ty, longint'(FIELD_H));
            pos_x[i] = px[14:0];
            pos_y[i] = py[13:0];
            vel_x[i] = vx[15:0];
            vel_y[i] = vy[15:0];
            want.which_particle = 6'(i);
            want.pixel_x        = pos_x[i][14:8];
            want.pixel_y        = pos_y[i][13:8];
            want.last           = (i == NUM_PARTICLES - 1);
            pending_pixels = {pending_pixels, want};
          end
          tick_count++;
        end else begin
          pos_x[in_data_i.particle_index] = {in_data_i.load_x, 8'h00};
          pos_y[in_data_i.particle_index] = {in_data_i.load_y, 8'h00};
          vel_x[in_data_i.particle_index] = '0;
          vel_y[in_data_i.particle_index] = '0;
          load_count++;
        end
      end
      pending = pending_pixels.size();
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dpw_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned SETTLE_CYCLES = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tick_count;
  int unsigned load_count;
  int unsigned pixel_count;
  int unsigned cfg_count;
  int unsigned idle_cycles;
  bit          hold_req = 1'b0;

  damped_particle_wall_bounce_step_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  dpw_checker u_pixel_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .tick_count_o  (tick_count),
    .load_count_o  (load_count),
    .pixel_count_o (pixel_count),
    .cfg_count_o   (cfg_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no beat moved for %0d cycles, %0d pixel beats outstanding", $time,
             IDLE_LIMIT, pending);
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver: changing stall styles, plus one long hold-off on request
  initial begin : receiver
    int unsigned style;
    int unsigned span;
    out_stall = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(50, 400);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (k % 4 == 3);
          endcase
        end
      end
    end
  end

  function automatic in_t make_load(input int idx, input int x, input int y);
    in_t b;
    b.mode           = MODE_LOAD;
    b.particle_index = 6'(idx);
    b.load_x         = 7'(x);
    b.load_y         = 6'(y);
    b.tilt_x         = 16'($urandom);
    b.tilt_y         = 16'($urandom);
    return b;
  endfunction

  function automatic in_t make_tick(input int tx, input int ty);
    in_t b;
    b.mode           = MODE_TICK;
    b.particle_index = 6'($urandom);
    b.load_x         = 7'($urandom);
    b.load_y         = 6'($urandom);
    b.tilt_x         = 16'(tx);
    b.tilt_y         = 16'(ty);
    return b;
  endfunction

  function automatic int new_bias();
    case ($urandom_range(0, 3))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_tilt(input int bias);
    int t;
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: begin
        t = bias + int'($urandom_range(0, 4000)) - 2000;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        return t[15:0];
      end
    endcase
  endfunction

  function automatic in_t rand_beat(input int bias_x, input int bias_y);
    in_t b;
    b.mode           = ($urandom_range(0, 99) < 40) ? MODE_TICK : MODE_LOAD;
    b.particle_index = 6'($urandom);
    b.load_x         = 7'($urandom);
    b.load_y         = 6'($urandom);
    b.tilt_x         = pick_tilt(bias_x);
    b.tilt_y         = pick_tilt(bias_y);
    return b;
  endfunction

  task automatic send_beat(input in_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [19:0] gain, input logic [15:0] damp);
    write_reg(CFG_ACCEL_GAIN, ($urandom & 32'hfff0_0000) | gain);
    write_reg(CFG_DAMPING, ($urandom & 32'hffff_0000) | damp);
    // unmapped index, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_DAMPING) + 1, (1 << CFG_IDX_W) - 1)), $urandom);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned n_items, input logic [19:0] gain,
                           input logic [15:0] damp, input bit with_hold);
    int bias_x;
    int bias_y;
    int unsigned burst;
    set_regs(gain, damp);
    bias_x = new_bias();
    bias_y = new_bias();
    if (with_hold) begin
      hold_req = 1'b1;
      repeat (4) send_beat(make_tick(bias_x, bias_y));
    end
    burst = $urandom_range(0, 12);
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        bias_x = new_bias();
        bias_y = new_bias();
      end
      send_beat(rand_beat(bias_x, bias_y));
      if (k == n_items / 2) begin
        drain_results();
      end else if (burst == 0) begin
        pause_sender($urandom_range(1, 15));
        burst = $urandom_range(0, 12);
      end else begin
        burst--;
      end
    end
    drain_results();
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corners, mid field and alternating bit patterns, default registers
    send_beat(make_load(0, 0, 0));
    send_beat(make_load(63, 127, 63));
    send_beat(make_load(1, 127, 0));
    send_beat(make_load(2, 0, 63));
    send_beat(make_load(3, 64, 32));
    send_beat(make_load(42, 85, 21));
    send_beat(make_load(21, 42, 42));
    send_beat(make_tick(0, 0));
    send_beat(make_tick(32767, 32767));
    send_beat(make_tick(32767, 32767));
    pause_sender(5);
    send_beat(make_tick(-32768, -32768));
    send_beat(make_tick(-32768, -32768));
    send_beat(make_tick(32767, -32768));
    // reload clears velocity
    send_beat(make_load(0, 127, 63));
    send_beat(make_tick(-1, 1));
    send_beat(make_tick(-32768, 32767));
    send_beat(make_load(63, 0, 0));
    send_beat(make_tick(0, 0));
    send_beat(make_tick(16384, -16384));
    drain_results();

    run_phase(60, 20'hfffff, 16'hffff, 1'b1);
    run_phase(25, 20'h00000, 16'h0000, 1'b0);
    run_phase(75, 20'($urandom), 16'($urandom), 1'b0);
    run_phase(75, 20'($urandom), 16'hffff, 1'b0);

    $display("tb_top: %0d ticks and %0d loads sent, %0d pixel beats checked", tick_count,
             load_count, pixel_count);
    $display("tb_top: %0d register writes over five gain/damping settings, one long hold-off",
             cfg_count);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/dpw_pkg.sv
sv/dpw_mul.sv
sv/dpw_store.sv
sv/damped_particle_wall_bounce_step_unit.sv
tb/dpw_checker.sv
tb/tb_top.sv
